@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Both forms sample on the rising edge and are quiet while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/psd_pkg.sv @@
package psd_pkg;

	localparam int PADDR_W     = 5;
	localparam int CFG_DIM_W   = 7;
	localparam int PACKED_SIZE = 32;

	typedef enum logic [1:0] {
		FMT_RAW    = 2'd0,
		FMT_MASKED = 2'd1,
		FMT_PACKED = 2'd2,
		FMT_RSVD   = 2'd3
	} fmt_e_t;

	typedef enum logic [2:0] {
		REG_FORMAT = 3'd0,
		REG_WIDTH  = 3'd1,
		REG_HEIGHT = 3'd2,
		REG_BASE   = 3'd3,
		REG_FLIP   = 3'd4,
		REG_ORIGIN = 3'd5,
		REG_PITCH  = 3'd6,
		REG_NONE   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		fmt_e_t                 format;
		logic [CFG_DIM_W-1:0]   width_px;
		logic [CFG_DIM_W-1:0]   height_px;
		logic [7:0]             pal_base;
		logic [1:0]             flip_mode;
		logic [23:0]            dst_origin;
		logic [12:0]            dst_pitch;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		format:     FMT_RAW,
		width_px:   7'd32,
		height_px:  7'd32,
		pal_base:   8'd0,
		flip_mode:  2'd0,
		dst_origin: 24'd0,
		dst_pitch:  13'd320
	};

endpackage

@@ hw/rtl/psd_if.sv @@
interface psd_in_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [7:0] data_byte;

	modport source (output valid, output start_req, output data_byte, input ready);
	modport sink (input valid, input start_req, input data_byte, output ready);
endinterface

interface psd_out_if #(
	parameter int ADDR_BITS = 24
);
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] write_address;
	logic [7:0]           pixel_value;
	logic                 last;

	modport source (output valid, output write_address, output pixel_value, output last,
		input ready);
	modport sink (input valid, input write_address, input pixel_value, input last,
		output ready);
endinterface

@@ hw/rtl/psd_apb_regs.sv @@
module psd_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [psd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output psd_pkg::cfg_t              cfg
);
	import psd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_FORMAT: cfg_q.format     <= fmt_e_t'(pwdata[1:0]);
				REG_WIDTH:  cfg_q.width_px   <= pwdata[CFG_DIM_W-1:0];
				REG_HEIGHT: cfg_q.height_px  <= pwdata[CFG_DIM_W-1:0];
				REG_BASE:   cfg_q.pal_base   <= pwdata[7:0];
				REG_FLIP:   cfg_q.flip_mode  <= pwdata[1:0];
				REG_ORIGIN: cfg_q.dst_origin <= pwdata[23:0];
				REG_PITCH:  cfg_q.dst_pitch  <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FORMAT: prdata = 32'(cfg_q.format);
			REG_WIDTH:  prdata = 32'(cfg_q.width_px);
			REG_HEIGHT: prdata = 32'(cfg_q.height_px);
			REG_BASE:   prdata = 32'(cfg_q.pal_base);
			REG_FLIP:   prdata = 32'(cfg_q.flip_mode);
			REG_ORIGIN: prdata = 32'(cfg_q.dst_origin);
			REG_PITCH:  prdata = 32'(cfg_q.dst_pitch);
			default:    prdata = 32'd0;
		endcase
	end

endmodule

@@ hw/rtl/psd_engine.sv @@
`include "assert_macros.svh"

module psd_engine #(
	parameter int MAX_SPRITE_DIM = 64,
	parameter int ADDR_BITS      = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  psd_pkg::cfg_t        cfg,
	input  logic                 step_en,
	input  logic                 start_req,
	input  logic [7:0]           data_byte,
	output logic [1:0]           res_cnt,
	output logic [ADDR_BITS-1:0] res_addr0,
	output logic [ADDR_BITS-1:0] res_addr1,
	output logic [7:0]           res_val0,
	output logic [7:0]           res_val1
);
	import psd_pkg::*;

	localparam int DIM_W   = $clog2(MAX_SPRITE_DIM + 1);
	localparam int ROW_W   = $clog2(MAX_SPRITE_DIM);
	localparam int GRP_MAX = MAX_SPRITE_DIM / 4;
	localparam int COL_W   = $clog2(GRP_MAX);
	localparam int GRP_W   = $clog2(GRP_MAX + 1);
	localparam int LIM_W   = GRP_W + DIM_W;
	localparam int SZ_W    = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
	localparam int CW      = LIM_W + 2;

	typedef struct packed {
		logic [1:0]       plane;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [7:0]       pm;
		logic [3:0]       bc;
		logic             mask_next;
		logic             sprite_done;
	} st_t;

	localparam st_t ST_CLR = '{
		plane: '0, col: '0, row: '0, pm: '0, bc: '0,
		mask_next: 1'b1, sprite_done: 1'b0
	};

	function automatic logic [2:0] msb_idx(input logic [7:0] m);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (m[i]) r = 3'(i);
		end
		return r;
	endfunction

	st_t st_q, cur, nx;

	logic [DIM_W-1:0]     w_sat, h_sat, w_al;
	logic [GRP_W-1:0]     groups;
	logic [LIM_W-1:0]     area, limit;
	logic [COL_W:0]       col_inc;
	logic                 adv_wrap;
	logic [COL_W-1:0]     adv_col;
	logic [ROW_W:0]       adv_row, row_f;
	logic [CW-1:0]        pos;
	logic [ADDR_BITS-1:0] x_lin, x_pl, y_pl, xp0, xp1, x0, y_sel, ay;
	logic [2:0]           b0, b1;
	logic [7:0]           pm0, pm1, pm2, pm_fin;
	logic                 np, fl;

	// clear is skipped on the reserved format: that byte changes nothing
	assign cur = (start_req && cfg.format != FMT_RSVD) ? ST_CLR : st_q;

	assign w_sat = (SZ_W'(cfg.width_px) > SZ_W'(MAX_SPRITE_DIM)) ?
		DIM_W'(MAX_SPRITE_DIM) : DIM_W'(cfg.width_px);
	assign h_sat = (SZ_W'(cfg.height_px) > SZ_W'(MAX_SPRITE_DIM)) ?
		DIM_W'(MAX_SPRITE_DIM) : DIM_W'(cfg.height_px);
	assign w_al   = {w_sat[DIM_W-1:2], 2'b00};
	assign groups = GRP_W'(w_sat[DIM_W-1:2]);
	assign area   = LIM_W'(groups) * LIM_W'(h_sat);
	assign limit  = {area[LIM_W-1:3], 3'b000};

	// column/row advance, shared by raw and masked formats
	assign col_inc  = {1'b0, cur.col} + 1'b1;
	assign adv_wrap = CW'(col_inc) >= CW'(groups);
	assign adv_col  = adv_wrap ? '0 : col_inc[COL_W-1:0];
	assign adv_row  = {1'b0, cur.row} + (ROW_W + 1)'(adv_wrap);
	assign pos      = CW'(adv_row) * CW'(groups) + CW'(adv_col);
	assign row_f    = {1'b0, cur.row} + 1'b1;

	// x = 4*group + plane; mirrored coordinates wrap if limits shrank mid-sprite
	assign x_lin = ADDR_BITS'({cur.col, cur.plane});
	assign x_pl  = cfg.flip_mode[0] ? ADDR_BITS'(w_al) - x_lin - 1'b1 : x_lin;
	assign y_pl  = cfg.flip_mode[1] ?
		ADDR_BITS'(h_sat) - ADDR_BITS'(cur.row) - 1'b1 : ADDR_BITS'(cur.row);

	// packed: up to two set mask bits consumed per byte, highest first
	assign pm0 = cur.pm;
	assign b0  = msb_idx(pm0);
	assign pm1 = pm0 & ~(8'd1 << b0);
	assign b1  = msb_idx(pm1);
	assign pm2 = pm1 & ~(8'd1 << b1);
	assign xp0 = cfg.flip_mode[0] ?
		ADDR_BITS'(PACKED_SIZE) - ADDR_BITS'({~b0, cur.plane}) - 1'b1 :
		ADDR_BITS'({~b0, cur.plane});
	assign xp1 = cfg.flip_mode[0] ?
		ADDR_BITS'(PACKED_SIZE) - ADDR_BITS'({~b1, cur.plane}) - 1'b1 :
		ADDR_BITS'({~b1, cur.plane});

	always_comb begin
		nx      = cur;
		res_cnt = 2'd0;
		np      = 1'b0;
		fl      = 1'b0;
		pm_fin  = pm0;
		if (cfg.format != FMT_RSVD && !cur.sprite_done) begin
			unique case (cfg.format)
				FMT_RAW: begin
					if (groups == '0 || h_sat == '0) begin
						nx.sprite_done = 1'b1;
					end else begin
						res_cnt = 2'd1;
						nx.col  = adv_col;
						if (CW'(adv_row) >= CW'(h_sat)) np = 1'b1;
						else nx.row = adv_row[ROW_W-1:0];
					end
				end
				FMT_MASKED: begin
					if (limit == '0) begin
						nx.sprite_done = 1'b1;
					end else if (cur.mask_next) begin
						nx.pm        = data_byte;
						nx.bc        = 4'd7;
						nx.mask_next = 1'b0;
					end else begin
						if (cur.pm[cur.bc[2:0]]) res_cnt = 2'd1;
						nx.col = adv_col;
						if (cur.bc[2:0] == 3'd0) begin
							nx.mask_next = 1'b1;
							nx.bc        = 4'd0;
						end else begin
							nx.bc = {1'b0, cur.bc[2:0] - 3'd1};
						end
						if (pos >= CW'(limit)) np = 1'b1;
						else nx.row = adv_row[ROW_W-1:0];
					end
				end
				FMT_PACKED: begin
					if (cur.mask_next) begin
						nx.pm        = data_byte;
						nx.mask_next = 1'b0;
						fl           = (data_byte == 8'd0);
					end else begin
						if (pm0 != 8'd0) begin
							if (pm1 != 8'd0) begin
								res_cnt = 2'd2;
								pm_fin  = pm2;
							end else begin
								res_cnt = 2'd1;
								pm_fin  = pm1;
							end
						end
						nx.pm = pm_fin;
						fl    = (pm_fin == 8'd0);
					end
				end
				default: ;
			endcase
		end
		// end of a packed line
		if (fl) begin
			nx.mask_next = 1'b1;
			nx.pm        = 8'd0;
			if (CW'(row_f) >= CW'(PACKED_SIZE)) np = 1'b1;
			else nx.row = row_f[ROW_W-1:0];
		end
		if (np) begin
			nx.row       = '0;
			nx.col       = '0;
			nx.mask_next = 1'b1;
			nx.plane     = cur.plane + 2'd1;
			if (cur.plane == 2'd3) nx.sprite_done = 1'b1;
		end
	end

	always_comb begin
		if (cfg.format == FMT_PACKED) begin
			x0       = xp0;
			y_sel    = ADDR_BITS'(cur.row);
			res_val0 = {4'd0, data_byte[7:4]} + cfg.pal_base;
		end else begin
			x0       = x_pl;
			y_sel    = y_pl;
			res_val0 = data_byte + cfg.pal_base;
		end
	end

	assign res_val1  = {4'd0, data_byte[3:0]} + cfg.pal_base;
	assign ay        = y_sel * ADDR_BITS'(cfg.dst_pitch);
	assign res_addr0 = ADDR_BITS'(cfg.dst_origin) + ay + x0;
	assign res_addr1 = ADDR_BITS'(cfg.dst_origin) + ay + xp1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_CLR;
		else if (step_en) st_q <= nx;
	end

	`ASSERT_NEXT(a_done_sticky, clk, arst_n, step_en && !start_req && st_q.sprite_done, st_q.sprite_done, "finished sprite resumed without start")
	`ASSERT_NEXT(a_rsvd_hold, clk, arst_n, step_en && cfg.format == FMT_RSVD, st_q == $past(st_q), "reserved format changed position state")
	`ASSERT_IMPL(a_pair_packed, clk, arst_n, res_cnt == 2'd2, cfg.format == FMT_PACKED, "two writes from a non-packed byte")

endmodule

@@ hw/rtl/planar_sprite_decoder.sv @@
// Planar sprite decoder.
// byte_in carries the sprite byte stream (start_req on the first byte of a
// sprite); pix_out carries frame-buffer writes: address, pixel value, and
// last on the final write caused by a byte. Both use valid/ready.
// Format, size, base color, flips, origin and pitch must be set over the
// APB port (one register per word) only while no item is in flight; the
// block itself does not enforce this. An item is registered on entry and,
// once the result register can take it, decoded into that two-entry
// result register, from which its writes leave on pix_out.
// A byte yields zero, one or two writes; the result register drains one
// write per cycle while pix_out is ready, so raw and masked data run at one
// byte per cycle and packed data can run slower, bounded by the single-write
// output port.
// The next byte is taken while the current results are still waiting.
// If pix_out stalls, the result register holds and the input register
// fills, then byte_in drops ready; nothing is lost or repeated.
// Reset loads the register defaults and clears position state; no pass
// over any memory is needed, the block is ready right after reset.
`include "assert_macros.svh"

module planar_sprite_decoder #(
	parameter int MAX_SPRITE_DIM = 64,
	parameter int ADDR_BITS      = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [psd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	psd_in_if.sink                      byte_in,
	psd_out_if.source                   pix_out
);
	import psd_pkg::*;

	cfg_t                 cfg;
	logic                 valid_s1;
	logic                 start_s1;
	logic [7:0]           byte_s1;
	logic                 load_ok;
	logic                 consume;
	logic [1:0]           res_cnt;
	logic [ADDR_BITS-1:0] res_addr0, res_addr1;
	logic [7:0]           res_val0, res_val1;
	logic [1:0]           cnt_q;
	logic [ADDR_BITS-1:0] addr0_q, addr1_q;
	logic [7:0]           val0_q, val1_q;
	logic                 pop;

	psd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psd_engine #(
		.MAX_SPRITE_DIM (MAX_SPRITE_DIM),
		.ADDR_BITS      (ADDR_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step_en   (consume),
		.start_req (start_s1),
		.data_byte (byte_s1),
		.res_cnt   (res_cnt),
		.res_addr0 (res_addr0),
		.res_addr1 (res_addr1),
		.res_val0  (res_val0),
		.res_val1  (res_val1)
	);

	// result register can take a new pair once at most one write is left
	// and that one leaves this cycle
	assign pop           = pix_out.valid && pix_out.ready;
	assign load_ok       = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pix_out.ready);
	assign consume       = valid_s1 && load_ok;
	assign byte_in.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			start_s1 <= byte_in.start_req;
			byte_s1  <= byte_in.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (consume) begin
			cnt_q <= res_cnt;
		end else if (pop) begin
			cnt_q <= (cnt_q == 2'd2) ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			addr0_q <= res_addr0;
			val0_q  <= res_val0;
			addr1_q <= res_addr1;
			val1_q  <= res_val1;
		end else if (pop && cnt_q == 2'd2) begin
			addr0_q <= addr1_q;
			val0_q  <= val1_q;
		end
	end

	assign pix_out.valid         = (cnt_q != 2'd0);
	assign pix_out.write_address = addr0_q;
	assign pix_out.pixel_value   = val0_q;
	assign pix_out.last          = (cnt_q == 2'd1);

	`ASSERT_IMPL(a_no_load_full, clk, arst_n, cnt_q == 2'd2, !consume, "item decoded over two pending writes")
	`ASSERT_NEXT(a_pair_loaded, clk, arst_n, consume && res_cnt == 2'd2, cnt_q == 2'd2, "write pair not captured")
	`ASSERT_IMPL(a_ready_empty, clk, arst_n, !valid_s1, byte_in.ready, "input stage empty but not ready")

endmodule
